### hw/rtl/ata_pio_command_sequencer_core_defines.svh
`ifndef ATA_PIO_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define ATA_PIO_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ATA_SEQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in a cycle implies the consequent in the same cycle.
`define ATA_SEQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ata_seq_pkg.sv
`timescale 1ns / 1ps

package ata_seq_pkg;

    // Data words moved per sector.
    localparam int SECTOR_WORDS = 256;
    localparam int WCNT_W       = $clog2(SECTOR_WORDS + 1);
    localparam int LBA_W        = 28;

    localparam logic [31:0] LBA_MAX   = 32'h0FFF_FFFF;
    localparam logic [16:0] COUNT_MAX = 17'(2 * SECTOR_WORDS);

    // Operation codes on the input stream.
    localparam logic [2:0] OP_READ     = 3'd0;
    localparam logic [2:0] OP_WRITE    = 3'd1;
    localparam logic [2:0] OP_FLUSH    = 3'd2;
    localparam logic [2:0] OP_IDENT    = 3'd3;
    localparam logic [2:0] OP_BUS_DONE = 3'd4;
    localparam logic [2:0] OP_PAYLOAD  = 3'd5;

    // Command kinds, same numbering as the low bits of the request codes.
    localparam logic [1:0] CK_READ  = 2'd0;
    localparam logic [1:0] CK_WRITE = 2'd1;
    localparam logic [1:0] CK_FLUSH = 2'd2;
    localparam logic [1:0] CK_IDENT = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_BUS_WR      = 3'd0;
    localparam logic [2:0] KIND_BUS_RD      = 3'd1;
    localparam logic [2:0] KIND_SECTOR_WORD = 3'd2;
    localparam logic [2:0] KIND_IDENT_WORD  = 3'd3;
    localparam logic [2:0] KIND_DONE        = 3'd4;

    // Completion status.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_RANGE     = 3'd1;
    localparam logic [2:0] STS_COUNT     = 3'd2;
    localparam logic [2:0] STS_FLOATING  = 3'd3;
    localparam logic [2:0] STS_ZERO      = 3'd4;
    localparam logic [2:0] STS_DEV_ERROR = 3'd5;

    // Task-file register offsets from the I/O base.
    localparam logic [15:0] REG_DATA    = 16'h0000;
    localparam logic [15:0] REG_ERROR   = 16'h0001;
    localparam logic [15:0] REG_COUNT   = 16'h0002;
    localparam logic [15:0] REG_LBA_LO  = 16'h0003;
    localparam logic [15:0] REG_LBA_MID = 16'h0004;
    localparam logic [15:0] REG_LBA_HI  = 16'h0005;
    localparam logic [15:0] REG_DEVICE  = 16'h0006;
    localparam logic [15:0] REG_CMD_STS = 16'h0007;
    localparam logic [15:0] REG_CONTROL = 16'h0206;

    localparam logic [7:0] SEL_ID_MASTER  = 8'hA0;
    localparam logic [7:0] SEL_ID_SLAVE   = 8'hB0;
    localparam logic [7:0] SEL_LBA_MASTER = 8'hE0;
    localparam logic [7:0] SEL_LBA_SLAVE  = 8'hF0;
    localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;
    localparam logic [7:0] CMD_READ       = 8'h20;
    localparam logic [7:0] CMD_WRITE      = 8'h30;
    localparam logic [7:0] CMD_FLUSH      = 8'hE7;
    localparam logic [7:0] STAT_FLOATING  = 8'hFF;
    localparam int         STAT_BSY_BIT   = 7;
    localparam int         STAT_ERR_BIT   = 0;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] sector;
        logic [15:0] byte_count;
        logic [15:0] data_word;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] bus_address;
        logic [15:0] write_value;
        logic [15:0] out_word;
        logic [2:0]  status_code;
        logic        last;
    } result_t;

    // Up to two results per item; first goes out before second.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  room;
    } fifo_stat_t;

endpackage

### hw/rtl/ata_seq_fsm.sv
`timescale 1ns / 1ps

module ata_seq_fsm
    import ata_seq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  logic        drive_is_master,
    input  logic [15:0] io_base,
    output push_t       push
);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ID_SEL1,
        PH_ID_CTRL,
        PH_ID_SEL2,
        PH_ID_PROBE,
        PH_TF_DEV,
        PH_TF_ERR,
        PH_TF_CNT,
        PH_TF_LO,
        PH_TF_MID,
        PH_TF_HI,
        PH_TF_CMD,
        PH_ST_FIRST,
        PH_ST_POLL,
        PH_DATA_RD,
        PH_DATA_WR,
        PH_WAIT_PAY
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [1:0]         ck_reg, ck_next;
    logic [WCNT_W-1:0]  wd_reg, wd_next;
    logic [WCNT_W-1:0]  ww_reg, ww_next;
    logic               odd_reg, odd_next;
    logic [LBA_W-1:0]   lba_reg, lba_next;

    logic [WCNT_W-1:0]  wd_inc;
    logic [7:0]         st8;
    logic               do_issue;
    phase_t             issue_p;
    logic               do_finish;
    logic [2:0]         fin_st;
    logic               pay_word;
    logic [15:0]        pay_value;
    logic               has_word;
    result_t            word_res;
    logic               has_tail;
    result_t            tail_res;

    function automatic result_t finish_res(input logic [2:0] st);
        result_t r;
        r             = '0;
        r.kind        = KIND_DONE;
        r.status_code = st;
        r.last        = 1'b1;
        return r;
    endfunction

    // Bus access that belongs to phase p.
    function automatic result_t issue_res(input phase_t p, input logic [1:0] ck,
                                          input logic [LBA_W-1:0] lba,
                                          input logic master,
                                          input logic [15:0] base);
        result_t    r;
        logic [7:0] sel_id;
        logic [7:0] sel_lba;
        logic       rw;
        r       = '0;
        sel_id  = master ? SEL_ID_MASTER : SEL_ID_SLAVE;
        sel_lba = master ? SEL_LBA_MASTER : SEL_LBA_SLAVE;
        rw      = (ck == CK_READ) || (ck == CK_WRITE);
        r.kind  = KIND_BUS_WR;
        unique case (p)
            PH_ID_SEL1, PH_ID_SEL2:
            begin
                r.bus_address = base + REG_DEVICE;
                r.write_value = {8'h00, sel_id};
            end
            PH_ID_CTRL:
            begin
                r.bus_address = base + REG_CONTROL;
            end
            PH_ID_PROBE, PH_ST_FIRST, PH_ST_POLL:
            begin
                r.kind        = KIND_BUS_RD;
                r.bus_address = base + REG_CMD_STS;
            end
            PH_TF_DEV:
            begin
                r.bus_address = base + REG_DEVICE;
                if (ck == CK_IDENT)
                    r.write_value = {8'h00, sel_id};
                else if (rw)
                    r.write_value = {8'h00, sel_lba | {4'h0, lba[27:24]}};
                else
                    r.write_value = {8'h00, sel_lba};
            end
            PH_TF_ERR:
            begin
                r.bus_address = base + REG_ERROR;
            end
            PH_TF_CNT:
            begin
                r.bus_address = base + REG_COUNT;
                r.write_value = {15'h0000, rw};
            end
            PH_TF_LO:
            begin
                r.bus_address = base + REG_LBA_LO;
                r.write_value = rw ? {8'h00, lba[7:0]} : 16'h0000;
            end
            PH_TF_MID:
            begin
                r.bus_address = base + REG_LBA_MID;
                r.write_value = rw ? {8'h00, lba[15:8]} : 16'h0000;
            end
            PH_TF_HI:
            begin
                r.bus_address = base + REG_LBA_HI;
                r.write_value = rw ? {8'h00, lba[23:16]} : 16'h0000;
            end
            PH_TF_CMD:
            begin
                r.bus_address = base + REG_CMD_STS;
                unique case (ck)
                    CK_READ:  r.write_value = {8'h00, CMD_READ};
                    CK_WRITE: r.write_value = {8'h00, CMD_WRITE};
                    CK_FLUSH: r.write_value = {8'h00, CMD_FLUSH};
                    default:  r.write_value = {8'h00, CMD_IDENTIFY};
                endcase
            end
            PH_DATA_RD:
            begin
                r.kind        = KIND_BUS_RD;
                r.bus_address = base + REG_DATA;
            end
            default:
            begin
                // zero-padded data-port write
                r.bus_address = base + REG_DATA;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        ck_next    = ck_reg;
        wd_next    = wd_reg;
        ww_next    = ww_reg;
        odd_next   = odd_reg;
        lba_next   = lba_reg;
        wd_inc     = wd_reg + 1'b1;
        st8        = item.data_word[7:0];
        do_issue   = 1'b0;
        issue_p    = PH_IDLE;
        do_finish  = 1'b0;
        fin_st     = STS_OK;
        pay_word   = 1'b0;
        pay_value  = item.data_word;
        has_word   = 1'b0;
        word_res   = '0;
        has_tail   = 1'b0;
        tail_res   = '0;

        if (fire)
        begin
            if (item.operation <= OP_IDENT)
            begin
                // requests while a command runs are dropped
                if (phase_reg == PH_IDLE)
                begin
                    ck_next = item.operation[1:0];
                    if ((item.operation == OP_READ) || (item.operation == OP_WRITE))
                    begin
                        if (item.sector > LBA_MAX)
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_RANGE;
                        end
                        else if ({1'b0, item.byte_count} > COUNT_MAX)
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_COUNT;
                        end
                        else
                        begin
                            lba_next = item.sector[LBA_W-1:0];
                            ww_next  = WCNT_W'(({1'b0, item.byte_count} + 17'd1) >> 1);
                            odd_next = item.byte_count[0];
                            do_issue = 1'b1;
                            issue_p  = PH_TF_DEV;
                        end
                    end
                    else if (item.operation == OP_FLUSH)
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_DEV;
                    end
                    else
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_ID_SEL1;
                    end
                end
            end
            else if (item.operation == OP_BUS_DONE)
            begin
                unique case (phase_reg)
                    PH_ID_SEL1:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_ID_CTRL;
                    end
                    PH_ID_CTRL:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_ID_SEL2;
                    end
                    PH_ID_SEL2:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_ID_PROBE;
                    end
                    PH_ID_PROBE:
                    begin
                        if (st8 == STAT_FLOATING)
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_FLOATING;
                        end
                        else
                        begin
                            do_issue = 1'b1;
                            issue_p  = PH_TF_DEV;
                        end
                    end
                    PH_TF_DEV:
                    begin
                        do_issue = 1'b1;
                        if (ck_reg == CK_FLUSH)
                            issue_p = PH_TF_CMD;
                        else if (ck_reg == CK_IDENT)
                            issue_p = PH_TF_CNT;
                        else
                            issue_p = PH_TF_ERR;
                    end
                    PH_TF_ERR:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_CNT;
                    end
                    PH_TF_CNT:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_LO;
                    end
                    PH_TF_LO:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_MID;
                    end
                    PH_TF_MID:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_HI;
                    end
                    PH_TF_HI:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_TF_CMD;
                    end
                    PH_TF_CMD:
                    begin
                        do_issue = 1'b1;
                        issue_p  = PH_ST_FIRST;
                    end
                    PH_ST_FIRST, PH_ST_POLL:
                    begin
                        // only the first status read checks for an all-zero status
                        if ((phase_reg == PH_ST_FIRST) && (st8 == 8'h00))
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_ZERO;
                        end
                        else if (st8[STAT_BSY_BIT] && !st8[STAT_ERR_BIT])
                        begin
                            do_issue = 1'b1;
                            issue_p  = PH_ST_POLL;
                        end
                        else if (st8[STAT_ERR_BIT])
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_DEV_ERROR;
                        end
                        else
                        begin
                            wd_next = '0;
                            if (ck_reg == CK_FLUSH)
                            begin
                                do_finish = 1'b1;
                                fin_st    = STS_OK;
                            end
                            else if (ck_reg == CK_WRITE)
                            begin
                                if (ww_reg != '0)
                                    phase_next = PH_WAIT_PAY;
                                else
                                begin
                                    do_issue = 1'b1;
                                    issue_p  = PH_DATA_WR;
                                end
                            end
                            else
                            begin
                                do_issue = 1'b1;
                                issue_p  = PH_DATA_RD;
                            end
                        end
                    end
                    PH_DATA_RD:
                    begin
                        word_res.out_word = item.data_word;
                        if (ck_reg == CK_IDENT)
                        begin
                            has_word      = 1'b1;
                            word_res.kind = KIND_IDENT_WORD;
                        end
                        else if (wd_reg < ww_reg)
                        begin
                            has_word      = 1'b1;
                            word_res.kind = KIND_SECTOR_WORD;
                        end
                        wd_next = wd_inc;
                        if (wd_inc >= WCNT_W'(SECTOR_WORDS))
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_OK;
                        end
                        else
                        begin
                            do_issue = 1'b1;
                            issue_p  = PH_DATA_RD;
                        end
                    end
                    PH_DATA_WR:
                    begin
                        wd_next = wd_inc;
                        if (wd_inc >= WCNT_W'(SECTOR_WORDS))
                        begin
                            do_finish = 1'b1;
                            fin_st    = STS_OK;
                        end
                        else if (wd_inc < ww_reg)
                            phase_next = PH_WAIT_PAY;
                        else
                        begin
                            do_issue = 1'b1;
                            issue_p  = PH_DATA_WR;
                        end
                    end
                    default:
                    begin
                        // nothing outstanding: drop
                    end
                endcase
            end
            else if ((item.operation == OP_PAYLOAD) && (phase_reg == PH_WAIT_PAY))
            begin
                // mask the odd tail to its low byte
                if (odd_reg && (wd_inc == ww_reg))
                    pay_value = {8'h00, item.data_word[7:0]};
                pay_word = 1'b1;
                do_issue = 1'b1;
                issue_p  = PH_DATA_WR;
            end
        end

        if (do_issue)
        begin
            has_tail   = 1'b1;
            tail_res   = issue_res(issue_p, ck_next, lba_next, drive_is_master, io_base);
            if (pay_word)
                tail_res.write_value = pay_value;
            phase_next = issue_p;
        end
        else if (do_finish)
        begin
            has_tail   = 1'b1;
            tail_res   = finish_res(fin_st);
            phase_next = PH_IDLE;
        end

        push.count  = {1'b0, has_word} + {1'b0, has_tail};
        push.first  = has_word ? word_res : tail_res;
        push.second = tail_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ck_reg    <= '0;
            wd_reg    <= '0;
            ww_reg    <= '0;
            odd_reg   <= 1'b0;
            lba_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ck_reg    <= ck_next;
            wd_reg    <= wd_next;
            ww_reg    <= ww_next;
            odd_reg   <= odd_next;
            lba_reg   <= lba_next;
        end
    end

endmodule

### hw/rtl/ata_seq_fifo.sv
`timescale 1ns / 1ps

module ata_seq_fifo
    import ata_seq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    input  logic       out_ready,
    output logic       out_valid,
    output result_t    head,
    output fifo_stat_t stat
);

    result_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic                  pop;

    assign out_valid    = (level_reg != '0);
    assign pop          = out_valid && out_ready;
    assign head         = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign level_next   = level_reg + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(pop);

    // room for a worst-case item of two results
    assign stat.level = level_reg;
    assign stat.room  = (level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

### hw/rtl/ata_pio_command_sequencer_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  request, bus_done or payload word
// m_*       out        m_tvalid/m_tready  bus access, data word or done
// cfg_*     in         cfg_valid/cfg_ready register index and write data
//
// One input item is taken per cycle while the result queue has room for two results.
// An item waits in the input register until the queue has room; its results enter
// the queue at the next edge and leave one per cycle while m_tready is high; a data
// read gives up to two results, other items at most one. Reset is immediate: no
// clearing pass. A stall on m_* holds the input and s_tready once 3 of 4 entries fill.

`include "ata_pio_command_sequencer_core_defines.svh"

module ata_pio_command_sequencer_core
    import ata_seq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sector[31:0], byte_count[47:32], data_word[63:48]
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bus_address[15:0], write_value[31:16],
                                   // out_word[47:32], status_code[50:48], zero[55:51]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic CFG_DRIVE   = 1'b0;
    localparam logic CFG_IO_BASE = 1'b1;

    logic        in_valid_reg, in_valid_next;
    item_t       in_item_reg;
    logic        drive_is_master_reg, drive_is_master_next;
    logic [15:0] io_base_reg, io_base_next;
    logic        fire;
    logic        s_xfer;
    push_t       push;
    fifo_stat_t  fifo_stat;
    result_t     head;

    assign fire      = in_valid_reg && fifo_stat.room;
    assign s_tready  = !in_valid_reg || fire;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next        = in_valid_reg;
        drive_is_master_next = drive_is_master_reg;
        io_base_next         = io_base_reg;
        if (s_xfer)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DRIVE:   drive_is_master_next = cfg_data[0];
                CFG_IO_BASE: io_base_next         = cfg_data;
                default:     io_base_next         = io_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            drive_is_master_reg <= 1'b1;
            io_base_reg         <= 16'h01F0;
        end
        else
        begin
            in_valid_reg        <= in_valid_next;
            drive_is_master_reg <= drive_is_master_next;
            io_base_reg         <= io_base_next;
        end
    end

    // hold the item until the sequencer takes it
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_item_reg.operation  <= s_tuser;
            in_item_reg.sector     <= s_tdata[31:0];
            in_item_reg.byte_count <= s_tdata[47:32];
            in_item_reg.data_word  <= s_tdata[63:48];
        end
    end

    ata_seq_fsm u_fsm (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (in_item_reg),
        .drive_is_master (drive_is_master_reg),
        .io_base         (io_base_reg),
        .push            (push)
    );

    ata_seq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .head      (head),
        .stat      (fifo_stat)
    );

    assign m_tdata = {5'b00000, head.status_code, head.out_word,
                      head.write_value, head.bus_address};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `ATA_SEQ_ASSERT_ALWAYS(a_fifo_level, fifo_stat.level <= FIFO_LVL_W'(FIFO_DEPTH), "result queue overflow")
    `ATA_SEQ_ASSERT_IMPLY(a_push_on_fire, push.count != 2'd0, fire, "results without a taken item")
    `ATA_SEQ_ASSERT_IMPLY(a_pair_is_word, push.count == 2'd2, (push.first.kind == KIND_SECTOR_WORD) || (push.first.kind == KIND_IDENT_WORD), "two results not led by a data word")
    `ATA_SEQ_ASSERT_IMPLY(a_stall_cause, !s_tready, in_valid_reg && !fifo_stat.room, "input stalled without a full queue")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ata_seq_pkg::*;

    localparam int         DRAIN_CYCLES        = 8;
    localparam int         LONG_HOLD           = 300;
    localparam bit         CFG_DRIVE_IS_MASTER = 1'b0;
    localparam bit         CFG_IO_BASE         = 1'b1;
    localparam logic [2:0] OP_RSVD_6           = 3'd6;
    localparam logic [2:0] OP_RSVD_7           = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ID_SELECT,
        S_ID_CONTROL,
        S_ID_RESELECT,
        S_ID_PROBE,
        S_TF_DEVICE,
        S_TF_ERROR,
        S_TF_COUNT,
        S_TF_LBA_LO,
        S_TF_LBA_MID,
        S_TF_LBA_HI,
        S_TF_COMMAND,
        S_STATUS_FIRST,
        S_STATUS_POLL,
        S_DATA_IN,
        S_DATA_OUT,
        S_PAYLOAD_WAIT
    } seq_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Sequencer model state, updated on every accepted transfer
    logic        drive_master = 1'b1;
    logic [15:0] io_base_reg  = 16'h01F0;
    seq_phase_t  cur_phase    = S_IDLE;
    logic [1:0]  cmd_kind     = CK_READ;
    int          words_moved  = 0;
    int          words_needed = 0;
    logic        tail_odd     = 1'b0;
    logic [27:0] lba_held     = '0;
    result_t     results_due[$];

    int errors        = 0;
    int sent_items    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;

    ata_pio_command_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic result_t bus_access(logic [2:0] kind, logic [15:0] offset,
                                           logic [15:0] value);
        result_t r;
        r = '0;
        r.kind = kind;
        r.bus_address = io_base_reg + offset;
        r.write_value = value;
        return r;
    endfunction

    task automatic close_command(logic [2:0] status);
        result_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.status_code = status;
        r.last = 1'b1;
        results_due.push_back(r);
        cur_phase = S_IDLE;
    endtask

    // Queue the bus access that belongs to phase p and move there.
    task automatic enter_phase(seq_phase_t p);
        logic [7:0]  sel_id;
        logic [7:0]  sel_lba;
        logic        rw;
        logic [2:0]  kind;
        logic [15:0] offset;
        logic [15:0] value;
        sel_id = drive_master ? SEL_ID_MASTER : SEL_ID_SLAVE;
        sel_lba = drive_master ? SEL_LBA_MASTER : SEL_LBA_SLAVE;
        rw = (cmd_kind == CK_READ) || (cmd_kind == CK_WRITE);
        kind = KIND_BUS_WR;
        value = '0;
        cur_phase = p;
        case (p)
            S_ID_SELECT, S_ID_RESELECT:
            begin
                offset = REG_DEVICE;
                value = {8'h00, sel_id};
            end
            S_ID_CONTROL:
                offset = REG_CONTROL;
            S_ID_PROBE, S_STATUS_FIRST, S_STATUS_POLL:
            begin
                kind = KIND_BUS_RD;
                offset = REG_CMD_STS;
            end
            S_TF_DEVICE:
            begin
                offset = REG_DEVICE;
                if (cmd_kind == CK_IDENT)
                    value = {8'h00, sel_id};
                else if (rw)
                    value = {8'h00, sel_lba | {4'h0, lba_held[27:24]}};
                else
                    value = {8'h00, sel_lba};
            end
            S_TF_ERROR:
                offset = REG_ERROR;
            S_TF_COUNT:
            begin
                offset = REG_COUNT;
                value = rw ? 16'd1 : 16'd0;
            end
            S_TF_LBA_LO:
            begin
                offset = REG_LBA_LO;
                value = rw ? {8'h00, lba_held[7:0]} : 16'd0;
            end
            S_TF_LBA_MID:
            begin
                offset = REG_LBA_MID;
                value = rw ? {8'h00, lba_held[15:8]} : 16'd0;
            end
            S_TF_LBA_HI:
            begin
                offset = REG_LBA_HI;
                value = rw ? {8'h00, lba_held[23:16]} : 16'd0;
            end
            S_TF_COMMAND:
            begin
                offset = REG_CMD_STS;
                case (cmd_kind)
                    CK_READ:  value = {8'h00, CMD_READ};
                    CK_WRITE: value = {8'h00, CMD_WRITE};
                    CK_FLUSH: value = {8'h00, CMD_FLUSH};
                    default:  value = {8'h00, CMD_IDENTIFY};
                endcase
            end
            S_DATA_IN:
            begin
                kind = KIND_BUS_RD;
                offset = REG_DATA;
            end
            default:
                offset = REG_DATA;  // zero padding word
        endcase
        results_due.push_back(bus_access(kind, offset, value));
    endtask

    task automatic begin_transfer();
        words_moved = 0;
        if (cmd_kind == CK_FLUSH)
            close_command(STS_OK);
        else if (cmd_kind == CK_WRITE && words_needed > 0)
            cur_phase = S_PAYLOAD_WAIT;
        else if (cmd_kind == CK_WRITE)
            enter_phase(S_DATA_OUT);
        else
            enter_phase(S_DATA_IN);
    endtask

    task automatic judge_status(logic [7:0] st);
        if (st[STAT_BSY_BIT] && !st[STAT_ERR_BIT])
            enter_phase(S_STATUS_POLL);
        else if (st[STAT_ERR_BIT])
            close_command(STS_DEV_ERROR);
        else
            begin_transfer();
    endtask

    task automatic predict_bus_done(logic [15:0] data);
        result_t r;
        case (cur_phase)
            S_ID_SELECT:   enter_phase(S_ID_CONTROL);
            S_ID_CONTROL:  enter_phase(S_ID_RESELECT);
            S_ID_RESELECT: enter_phase(S_ID_PROBE);
            S_ID_PROBE:
                if (data[7:0] == STAT_FLOATING)
                    close_command(STS_FLOATING);
                else
                    enter_phase(S_TF_DEVICE);
            S_TF_DEVICE:
                if (cmd_kind == CK_FLUSH)
                    enter_phase(S_TF_COMMAND);
                else if (cmd_kind == CK_IDENT)
                    enter_phase(S_TF_COUNT);
                else
                    enter_phase(S_TF_ERROR);
            S_TF_ERROR:    enter_phase(S_TF_COUNT);
            S_TF_COUNT:    enter_phase(S_TF_LBA_LO);
            S_TF_LBA_LO:   enter_phase(S_TF_LBA_MID);
            S_TF_LBA_MID:  enter_phase(S_TF_LBA_HI);
            S_TF_LBA_HI:   enter_phase(S_TF_COMMAND);
            S_TF_COMMAND:  enter_phase(S_STATUS_FIRST);
            S_STATUS_FIRST:
                if (data[7:0] == 8'h00)
                    close_command(STS_ZERO);
                else
                    judge_status(data[7:0]);
            S_STATUS_POLL: judge_status(data[7:0]);
            S_DATA_IN:
            begin
                r = '0;
                r.out_word = data;
                // forward identify words always, sector words up to the byte count
                if (cmd_kind == CK_IDENT)
                begin
                    r.kind = KIND_IDENT_WORD;
                    results_due.push_back(r);
                end
                else if (words_moved < words_needed)
                begin
                    r.kind = KIND_SECTOR_WORD;
                    results_due.push_back(r);
                end
                words_moved++;
                if (words_moved >= SECTOR_WORDS)
                    close_command(STS_OK);
                else
                    enter_phase(S_DATA_IN);
            end
            S_DATA_OUT:
            begin
                words_moved++;
                if (words_moved >= SECTOR_WORDS)
                    close_command(STS_OK);
                else if (words_moved < words_needed)
                    cur_phase = S_PAYLOAD_WAIT;
                else
                    enter_phase(S_DATA_OUT);
            end
            default: ;
        endcase
    endtask

    task automatic predict_item(logic [2:0] op, logic [31:0] sector, logic [15:0] count,
                                logic [15:0] data);
        logic [15:0] value;
        if (op <= OP_IDENT)
        begin
            if (cur_phase == S_IDLE)
            begin
                cmd_kind = op[1:0];
                if (op == OP_READ || op == OP_WRITE)
                begin
                    if (sector > LBA_MAX)
                        close_command(STS_RANGE);
                    else if ({1'b0, count} > COUNT_MAX)
                        close_command(STS_COUNT);
                    else
                    begin
                        lba_held = sector[27:0];
                        words_needed = (int'(count) + 1) / 2;
                        tail_odd = count[0];
                        enter_phase(S_TF_DEVICE);
                    end
                end
                else if (op == OP_FLUSH)
                    enter_phase(S_TF_DEVICE);
                else
                    enter_phase(S_ID_SELECT);
            end
        end
        else if (op == OP_BUS_DONE)
            predict_bus_done(data);
        else if (op == OP_PAYLOAD && cur_phase == S_PAYLOAD_WAIT)
        begin
            value = data;
            // mask the odd last byte of the payload
            if (tail_odd && words_moved + 1 == words_needed)
                value[15:8] = 8'h00;
            cur_phase = S_DATA_OUT;
            results_due.push_back(bus_access(KIND_BUS_WR, REG_DATA, value));
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DRIVE_IS_MASTER)
                    drive_master = cfg_data[0];
                else
                    io_base_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_item(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[63:48]);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.bus_address = m_tdata[15:0];
                got.write_value = m_tdata[31:16];
                got.out_word = m_tdata[47:32];
                got.status_code = m_tdata[50:48];
                got.last = m_tlast;
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected %0d %h %h %h %0d %0d",
                                 $realtime, got.kind, got.bus_address, got.write_value,
                                 got.out_word, got.status_code, got.last);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.bus_address !== want.bus_address
                        || got.write_value !== want.write_value
                        || got.out_word !== want.out_word
                        || got.status_code !== want.status_code || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected %0d %h %h %h %0d %0d got %0d %h %h %h %0d %0d",
                                     $realtime, want.kind, want.bus_address, want.write_value,
                                     want.out_word, want.status_code, want.last, got.kind,
                                     got.bus_address, got.write_value, got.out_word,
                                     got.status_code, got.last);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item from a falling edge and return at the falling edge after its transfer.
    task automatic send_item(logic [2:0] op, logic [31:0] sector, logic [15:0] count,
                             logic [15:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser = op;
        s_tdata = {data, count, sector};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        s_tvalid = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(bit index, logic [15:0] value);
        wait_quiet();
        cfg_index = index;
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send an item the block ignores in the current phase.
    task automatic send_noise();
        logic [2:0] op;
        do
            op = 3'($urandom_range(7));
        while ((op == OP_BUS_DONE && cur_phase != S_IDLE && cur_phase != S_PAYLOAD_WAIT)
               || (op == OP_PAYLOAD && cur_phase == S_PAYLOAD_WAIT)
               || (op <= OP_IDENT && cur_phase == S_IDLE));
        send_item(op, $urandom(), 16'($urandom()), 16'($urandom()));
    endtask

    // Answer the outstanding access; wild answers include floating, busy and error status.
    task automatic answer_step(bit wild);
        logic [2:0]  op;
        logic [15:0] word;
        int          pick;
        op = OP_BUS_DONE;
        word = 16'($urandom());
        pick = $urandom_range(99);
        case (cur_phase)
            S_PAYLOAD_WAIT:
                op = OP_PAYLOAD;
            S_ID_PROBE:
                if (wild && pick < 10)
                    word[7:0] = STAT_FLOATING;
                else if (word[7:0] == STAT_FLOATING)
                    word[7:0] = 8'h50;
            S_STATUS_FIRST:
                if (!wild || pick >= 45)
                begin
                    word[7:0] = word[7:0] & 8'h7E;
                    if (word[7:0] == 8'h00)
                        word[7:0] = 8'h40;
                end
                else if (pick < 8)
                    word[7:0] = 8'h00;
                else if (pick < 18)
                    word[STAT_ERR_BIT] = 1'b1;
                else
                begin
                    word[STAT_BSY_BIT] = 1'b1;
                    word[STAT_ERR_BIT] = 1'b0;
                end
            S_STATUS_POLL:
                if (!wild || pick >= 45)
                    word[7:0] = word[7:0] & 8'h7E;
                else if (pick < 35)
                begin
                    word[STAT_BSY_BIT] = 1'b1;
                    word[STAT_ERR_BIT] = 1'b0;
                end
                else
                    word[STAT_ERR_BIT] = 1'b1;
            default: ;
        endcase
        send_item(op, $urandom(), 16'($urandom()), word);
        sent_items++;
    endtask

    task automatic advance_to(seq_phase_t target);
        while (cur_phase != target)
            answer_step(1'b0);
    endtask

    task automatic run_command(logic [2:0] op, logic [31:0] sector, logic [15:0] count,
                               bit wild);
        send_item(op, sector, count, 16'($urandom()));
        sent_items++;
        while (cur_phase != S_IDLE)
        begin
            if (wild && $urandom_range(99) < 6)
                send_noise();
            else
                answer_step(wild);
        end
    endtask

    task automatic test_rejected_requests();
        send_item(OP_READ, 32'h1000_0000, 16'd0, 16'h0000);
        send_item(OP_WRITE, 32'hFFFF_FFFF, 16'd512, 16'hFFFF);
        send_item(OP_READ, LBA_MAX, 16'd513, 16'h0000);
        send_item(OP_WRITE, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
        // nothing is outstanding, so these drop silently
        send_item(OP_BUS_DONE, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_PAYLOAD, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_RSVD_6, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_RSVD_7, $urandom(), 16'($urandom()), 16'($urandom()));
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_IO_BASE, 16'hFFFF);
        write_reg(CFG_DRIVE_IS_MASTER, 16'h0000);
        run_command(OP_FLUSH, $urandom(), 16'($urandom()), 1'b0);
        write_reg(CFG_IO_BASE, 16'h0000);
        write_reg(CFG_DRIVE_IS_MASTER, 16'hFFFF);
        run_command(OP_FLUSH, $urandom(), 16'($urandom()), 1'b0);
        write_reg(CFG_IO_BASE, 16'h01F0);
    endtask

    task automatic test_identify();
        run_command(OP_IDENT, $urandom(), 16'($urandom()), 1'b0);
        write_reg(CFG_DRIVE_IS_MASTER, 16'h0000);
        send_item(OP_IDENT, $urandom(), 16'($urandom()), 16'($urandom()));
        advance_to(S_ID_PROBE);
        send_item(OP_BUS_DONE, $urandom(), 16'($urandom()), 16'h5AFF);
        send_item(OP_IDENT, $urandom(), 16'($urandom()), 16'($urandom()));
        advance_to(S_STATUS_FIRST);
        send_item(OP_BUS_DONE, $urandom(), 16'($urandom()), 16'hFE01);
        write_reg(CFG_DRIVE_IS_MASTER, 16'h0001);
    endtask

    task automatic test_status_handling();
        // zero in the low byte on the first status read
        send_item(OP_FLUSH, 32'h0, 16'h0, 16'h0);
        advance_to(S_STATUS_FIRST);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'hFF00);
        // busy twice, then error while still busy
        send_item(OP_FLUSH, 32'h0, 16'h0, 16'h0);
        advance_to(S_STATUS_FIRST);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'h0080);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'h00C0);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'h0081);
        // zero during polling counts as ready
        send_item(OP_FLUSH, 32'h0, 16'h0, 16'h0);
        advance_to(S_STATUS_FIRST);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'h0080);
        send_item(OP_BUS_DONE, 32'h0, 16'h0, 16'h0000);
    endtask

    task automatic test_ignored_items();
        send_item(OP_FLUSH, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_READ, 32'h0, 16'd2, 16'h0);
        send_item(OP_IDENT, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_PAYLOAD, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_RSVD_7, $urandom(), 16'($urandom()), 16'($urandom()));
        advance_to(S_IDLE);
    endtask

    task automatic test_write_tail();
        send_item(OP_WRITE, LBA_MAX, 16'd3, 16'h0000);
        advance_to(S_PAYLOAD_WAIT);
        // bus_done and requests drop while a payload word is awaited
        send_item(OP_BUS_DONE, $urandom(), 16'($urandom()), 16'($urandom()));
        send_item(OP_FLUSH, $urandom(), 16'($urandom()), 16'($urandom()));
        advance_to(S_IDLE);
    endtask

    task automatic test_random(int budget);
        int          stop_at;
        int          pick;
        logic [2:0]  op;
        logic [31:0] sector;
        logic [15:0] count;
        stop_at = sent_items + budget;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(99) < 12)
            begin
                write_reg(CFG_DRIVE_IS_MASTER, 16'($urandom()));
                pick = $urandom_range(3);
                case (pick)
                    0:       write_reg(CFG_IO_BASE, 16'h0000);
                    1:       write_reg(CFG_IO_BASE, 16'hFFFF);
                    default: write_reg(CFG_IO_BASE, 16'($urandom()));
                endcase
            end
            op = 3'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 8)
                sector = $urandom() | 32'h1000_0000;
            else if (pick < 14)
                sector = LBA_MAX;
            else if (pick < 18)
                sector = 32'h0;
            else
                sector = {4'h0, 28'($urandom())};
            pick = $urandom_range(99);
            if (pick < 8)
                count = 16'($urandom_range(65535, 513));
            else if (pick < 20)
                count = 16'd0;
            else if (pick < 30)
                count = 16'd1;
            else if (pick < 40)
                count = 16'd511;
            else if (pick < 50)
                count = 16'd512;
            else
                count = 16'($urandom_range(512));
            run_command(op, sector, count, 1'b1);
        end
    endtask

    // Stall the result side during a read data phase while items keep coming.
    task automatic test_backpressure();
        send_item(OP_READ, {4'h0, 28'($urandom())}, 16'd512, 16'($urandom()));
        advance_to(S_DATA_IN);
        hold_requests <= hold_requests + 1;
        advance_to(S_IDLE);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_READ;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DRIVE_IS_MASTER;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        send_idle_pct = 34;
        recv_idle_pct = 69;
        test_rejected_requests();
        test_register_extremes();
        test_identify();
        test_status_handling();
        test_ignored_items();
        test_write_tail();
        test_random(300);
        send_idle_pct = 69;
        recv_idle_pct = 34;
        test_random(300);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        wait_quiet();
        if (errors == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
